### design/nms_pkg.sv
// Shared types and codes for the box suppression block.
package nms_pkg;

  typedef struct packed {
    logic signed [15:0] y2;
    logic signed [15:0] x2;
    logic signed [15:0] y1;
    logic signed [15:0] x1;
  } box_t;

  typedef enum logic [2:0] {
    OUT_KEPT       = 3'd0,
    OUT_SUPPRESSED = 3'd1,
    OUT_BELOW      = 3'd2,
    OUT_OVER_CAND  = 3'd3,
    OUT_LIMIT      = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SCORE_THR = 2'd0,
    REG_IOU_THR   = 2'd1,
    REG_CAND_LIM  = 2'd2,
    REG_RES_LIM   = 2'd3
  } cfg_reg_t;

endpackage

### design/nms_cell.sv
// One kept-box cell: stores a box and tests the passing probe for overlap.
module nms_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [CW-1:0]        count,
  input  logic [8:0]           iou_threshold,
  input  nms_pkg::box_t        probe_in,
  input  logic                 flag_in,
  output nms_pkg::box_t        probe_out,
  output logic                 flag_out
);

  nms_pkg::box_t kept;

  logic               s1_valid;
  logic signed [16:0] s1_iw, s1_ih, s1_aw, s1_ah, s1_bw, s1_bh;
  logic               s2_valid;
  logic signed [33:0] s2_inter, s2_area_a, s2_area_b;
  logic               s3_valid;
  logic signed [35:0] s3_uni;
  logic signed [33:0] s3_inter;

  logic signed [16:0] iw_raw, ih_raw;
  logic signed [15:0] lx, rx, ty, by;
  logic signed [45:0] rhs;
  logic signed [45:0] lhs;
  logic               hit;

  always_comb begin
    lx = (kept.x1 > probe_in.x1) ? kept.x1 : probe_in.x1;
    rx = (kept.x2 < probe_in.x2) ? kept.x2 : probe_in.x2;
    ty = (kept.y1 > probe_in.y1) ? kept.y1 : probe_in.y1;
    by = (kept.y2 < probe_in.y2) ? kept.y2 : probe_in.y2;
    iw_raw = 17'(rx) - 17'(lx);
    ih_raw = 17'(by) - 17'(ty);
    rhs = $signed({1'b0, iou_threshold}) * s3_uni;
    lhs = 46'(s3_inter) <<< 8;
    hit = s3_valid && (s3_uni > 36'sd0) && (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (load && count == CW'(IDX)) begin
      kept <= probe_in;
    end
    s1_valid <= (count > CW'(IDX));
    s1_iw <= iw_raw[16] ? 17'sd0 : iw_raw;
    s1_ih <= ih_raw[16] ? 17'sd0 : ih_raw;
    s1_aw <= 17'(kept.x2) - 17'(kept.x1);
    s1_ah <= 17'(kept.y2) - 17'(kept.y1);
    s1_bw <= 17'(probe_in.x2) - 17'(probe_in.x1);
    s1_bh <= 17'(probe_in.y2) - 17'(probe_in.y1);
    s2_valid <= s1_valid;
    s2_inter <= s1_iw * s1_ih;
    s2_area_a <= s1_aw * s1_ah;
    s2_area_b <= s1_bw * s1_bh;
    s3_valid <= s2_valid;
    s3_uni <= 36'(s2_area_a) + 36'(s2_area_b) - 36'(s2_inter);
    s3_inter <= s2_inter;
    probe_out <= probe_in;
    if (rst) begin
      flag_out <= 1'b0;
    end else begin
      flag_out <= flag_in | hit;
    end
  end

endmodule

### design/greedy_iou_box_suppression.sv
// Top level: greedy IoU suppression with a row of kept-box cells.
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, box_*, frame_last    | request in
//   out     | out_valid, out_stall, outcome, kept_*    | request out
//   cfg     | cfg_write, cfg_index, cfg_data           | register write
// A request dropped by score or a limit yields its result in the cycle after accept.
// A request that is scanned walks the probe along the cell row, one cell a cycle,
// and each cell tests it in a four-stage overlap pipeline.
// One request in flight; a held result blocks input only while out_stall is high.
// Synchronous reset clears the counters and sets the threshold and limit registers to their defaults.
module greedy_iou_box_suppression #(
  parameter int MAX_KEPT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] box_x1,
  input  logic signed [15:0] box_y1,
  input  logic signed [15:0] box_x2,
  input  logic signed [15:0] box_y2,
  input  logic [15:0]        box_score,
  input  logic               frame_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         outcome,
  output logic [5:0]         kept_slot,
  output logic signed [15:0] kept_x1,
  output logic signed [15:0] kept_y1,
  output logic signed [15:0] kept_x2,
  output logic signed [15:0] kept_y2,
  output logic [15:0]        kept_score,
  output logic               result_last
);

  localparam int CW   = $clog2(MAX_KEPT + 1);
  localparam int NW   = $clog2(MAX_KEPT + 4);
  localparam int DONE = MAX_KEPT + 3;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t        state;
  logic [15:0]   score_threshold;
  logic [8:0]    iou_threshold;
  logic [15:0]   candidate_limit;
  logic [6:0]    result_limit;
  logic [CW-1:0] kept_count;
  logic [15:0]   candidate_count;
  logic [NW-1:0] step;
  nms_pkg::box_t item;
  logic          item_last;

  nms_pkg::box_t probe [MAX_KEPT+1];
  logic          flag  [MAX_KEPT+1];

  logic accept, at_limit, scan_end, load;

  assign in_stall = (state == ST_SCAN) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign at_limit = (9'(kept_count) >= 9'(result_limit)) || (kept_count == CW'(MAX_KEPT));
  assign scan_end = (state == ST_SCAN) && (step == NW'(DONE));
  assign load     = scan_end && !flag[MAX_KEPT];

  assign probe[0] = item;
  assign flag[0]  = 1'b0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    nms_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .load          (load),
      .count         (kept_count),
      .iou_threshold (iou_threshold),
      .probe_in      (probe[i]),
      .flag_in       (flag[i]),
      .probe_out     (probe[i+1]),
      .flag_out      (flag[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      score_threshold <= 16'd32768;
      iou_threshold   <= 9'd102;
      candidate_limit <= 16'd4096;
      result_limit    <= 7'd64;
      kept_count      <= '0;
      candidate_count <= '0;
      step            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (nms_pkg::cfg_reg_t'(cfg_index))
          nms_pkg::REG_SCORE_THR: score_threshold <= cfg_data;
          nms_pkg::REG_IOU_THR:   iou_threshold   <= cfg_data[8:0];
          nms_pkg::REG_CAND_LIM:  candidate_limit <= cfg_data;
          nms_pkg::REG_RES_LIM:   result_limit    <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item        <= '{y2: box_y2, x2: box_x2, y1: box_y1, x1: box_x1};
            item_last   <= frame_last;
            kept_x1     <= box_x1;
            kept_y1     <= box_y1;
            kept_x2     <= box_x2;
            kept_y2     <= box_y2;
            kept_score  <= box_score;
            result_last <= frame_last;
            kept_slot   <= '0;
            if (box_score < score_threshold) begin
              outcome   <= nms_pkg::OUT_BELOW;
              out_valid <= 1'b1;
            end else if (candidate_count >= candidate_limit) begin
              outcome   <= nms_pkg::OUT_OVER_CAND;
              out_valid <= 1'b1;
            end else begin
              candidate_count <= candidate_count + 16'd1;
              if (at_limit) begin
                outcome   <= nms_pkg::OUT_LIMIT;
                out_valid <= 1'b1;
              end else begin
                state <= ST_SCAN;
                step  <= '0;
              end
            end
            if (frame_last && !(box_score >= score_threshold &&
                candidate_count < candidate_limit && !at_limit)) begin
              kept_count      <= '0;
              candidate_count <= '0;
            end
          end
        end
        ST_SCAN: begin
          step <= step + NW'(1);
          if (scan_end) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            if (flag[MAX_KEPT]) begin
              outcome <= nms_pkg::OUT_SUPPRESSED;
            end else begin
              outcome    <= nms_pkg::OUT_KEPT;
              kept_slot  <= 6'(kept_count);
              kept_count <= kept_count + CW'(1);
            end
            if (item_last) begin
              kept_count      <= '0;
              candidate_count <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### bench/nms_outcome_checker.sv
// Checker for the box suppression block: predicts each outcome and compares the results.
module nms_outcome_checker #(
  parameter int MAX_KEPT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] box_x1,
  input  logic signed [15:0] box_y1,
  input  logic signed [15:0] box_x2,
  input  logic signed [15:0] box_y2,
  input  logic [15:0]        box_score,
  input  logic               frame_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         outcome,
  input  logic [5:0]         kept_slot,
  input  logic signed [15:0] kept_x1,
  input  logic signed [15:0] kept_y1,
  input  logic signed [15:0] kept_x2,
  input  logic signed [15:0] kept_y2,
  input  logic [15:0]        kept_score,
  input  logic               result_last,
  output int                 fail_count,
  output int                 pending,
  output int                 kept_total,
  output int                 suppressed_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    nms_pkg::outcome_t oc;
    logic [5:0]        slot;
    nms_pkg::box_t     bx;
    logic [15:0]       score;
    logic              last;
  } box_verdict_t;

  box_verdict_t  verdict_q[$];
  nms_pkg::box_t kept_store[MAX_KEPT];
  int            kept_n;
  logic [15:0]   cand_n;
  logic [15:0]   score_thr;
  logic [8:0]    iou_thr;
  logic [15:0]   cand_lim;
  logic [6:0]    res_lim;

  function automatic bit overlaps_too_much(nms_pkg::box_t a, nms_pkg::box_t b,
                                           logic [8:0] thr);
    longint iw, ih, inter, area_a, area_b, uni;
    iw = ((a.x2 < b.x2) ? longint'(a.x2) : longint'(b.x2))
       - ((a.x1 > b.x1) ? longint'(a.x1) : longint'(b.x1));
    ih = ((a.y2 < b.y2) ? longint'(a.y2) : longint'(b.y2))
       - ((a.y1 > b.y1) ? longint'(a.y1) : longint'(b.y1));
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    area_a = (longint'(a.x2) - longint'(a.x1)) * (longint'(a.y2) - longint'(a.y1));
    area_b = (longint'(b.x2) - longint'(b.x1)) * (longint'(b.y2) - longint'(b.y1));
    uni = area_a + area_b - inter;
    if (uni <= 0) return 0;
    return inter * 256 > longint'(thr) * uni;
  endfunction

  function automatic box_verdict_t judge_box(nms_pkg::box_t bx, logic [15:0] score,
                                             logic last);
    box_verdict_t v;
    int limit;
    bit supp;
    v.oc = nms_pkg::OUT_KEPT;
    v.slot = '0;
    v.bx = bx;
    v.score = score;
    v.last = last;
    limit = (res_lim < MAX_KEPT) ? int'(res_lim) : MAX_KEPT;
    if (score < score_thr) begin
      v.oc = nms_pkg::OUT_BELOW;
    end else if (cand_n >= cand_lim) begin
      v.oc = nms_pkg::OUT_OVER_CAND;
    end else begin
      cand_n = cand_n + 16'd1;
      if (kept_n >= limit) begin
        v.oc = nms_pkg::OUT_LIMIT;
      end else begin
        supp = 0;
        for (int i = 0; i < kept_n; i++)
          if (!supp && overlaps_too_much(kept_store[i], bx, iou_thr)) supp = 1;
        if (supp) begin
          v.oc = nms_pkg::OUT_SUPPRESSED;
        end else begin
          v.slot = kept_n[5:0];
          kept_store[kept_n] = bx;
          kept_n++;
        end
      end
    end
    if (last) begin
      kept_n = 0;
      cand_n = '0;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    box_verdict_t v;
    nms_pkg::box_t bx;
    if (rst) begin
      verdict_q.delete();
      kept_n = 0;
      cand_n = '0;
      score_thr = 16'd32768;
      iou_thr = 9'd102;
      cand_lim = 16'd4096;
      res_lim = 7'd64;
      fail_count = 0;
      kept_total = 0;
      suppressed_total = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          nms_pkg::REG_SCORE_THR: score_thr = cfg_data;
          nms_pkg::REG_IOU_THR:   iou_thr = cfg_data[8:0];
          nms_pkg::REG_CAND_LIM:  cand_lim = cfg_data;
          nms_pkg::REG_RES_LIM:   res_lim = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: outcome %0d", outcome);
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (v.oc == nms_pkg::OUT_KEPT) kept_total++;
          if (v.oc == nms_pkg::OUT_SUPPRESSED) suppressed_total++;
          if (outcome != v.oc) begin
            $error("outcome: expected %0d, got %0d", v.oc, outcome); fail_count++;
          end
          if (kept_slot != v.slot) begin
            $error("kept_slot: expected %0d, got %0d", v.slot, kept_slot); fail_count++;
          end
          if (kept_x1 != v.bx.x1) begin
            $error("kept_x1: expected %0d, got %0d", v.bx.x1, kept_x1); fail_count++;
          end
          if (kept_y1 != v.bx.y1) begin
            $error("kept_y1: expected %0d, got %0d", v.bx.y1, kept_y1); fail_count++;
          end
          if (kept_x2 != v.bx.x2) begin
            $error("kept_x2: expected %0d, got %0d", v.bx.x2, kept_x2); fail_count++;
          end
          if (kept_y2 != v.bx.y2) begin
            $error("kept_y2: expected %0d, got %0d", v.bx.y2, kept_y2); fail_count++;
          end
          if (kept_score != v.score) begin
            $error("kept_score: expected %0d, got %0d", v.score, kept_score); fail_count++;
          end
          if (result_last != v.last) begin
            $error("result_last: expected %0d, got %0d", v.last, result_last); fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        bx.x1 = box_x1;
        bx.y1 = box_y1;
        bx.x2 = box_x2;
        bx.y2 = box_y2;
        v = judge_box(bx, box_score, frame_last);
        verdict_q.insert(verdict_q.size(), v);
      end
    end
    pending = verdict_q.size();
  end
endmodule

### bench/greedy_iou_box_suppression_tb.sv
// Testbench top: drives box requests and register writes, and gives the verdict.
module greedy_iou_box_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 100;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] box_x1, box_y1, box_x2, box_y2;
  logic [15:0]        box_score;
  logic               frame_last;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         outcome;
  logic [5:0]         kept_slot;
  logic signed [15:0] kept_x1, kept_y1, kept_x2, kept_y2;
  logic [15:0]        kept_score;
  logic               result_last;
  int                 fail_count, pending, kept_total, suppressed_total;
  int                 boxes_sent;
  int                 cycles;

  greedy_iou_box_suppression dut (.*);

  nms_outcome_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("greedy_iou_box_suppression_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, bursts with none, one long hold-off to back up the block
  initial begin
    int gap, burst, taken;
    burst = 0;
    taken = 0;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
      end
      repeat (gap) @(negedge clk) out_stall <= 1;
      @(negedge clk) out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken == 150) repeat (600) @(negedge clk) out_stall <= 1;
    end
  end

  task automatic send_box(input logic signed [15:0] x1, y1, x2, y2,
                          input logic [15:0] score, input logic last);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk) in_valid <= 0;
    @(negedge clk);
    box_x1 <= x1;
    box_y1 <= y1;
    box_x2 <= x2;
    box_y2 <= y2;
    box_score <= score;
    frame_last <= last;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    boxes_sent++;
  endtask

  task automatic write_reg(input nms_pkg::cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk) cfg_write <= 0;
  endtask

  task automatic drain_block();
    @(negedge clk) in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] s, i, c, r);
    drain_block();
    write_reg(nms_pkg::REG_SCORE_THR, s);
    write_reg(nms_pkg::REG_IOU_THR, i);
    write_reg(nms_pkg::REG_CAND_LIM, c);
    write_reg(nms_pkg::REG_RES_LIM, r);
  endtask

  task automatic send_frame(input int budget);
    int len, mode, cx, cy, w, h, step;
    logic [15:0] score;
    logic signed [15:0] x1, y1;
    int cxs[4], cys[4];
    len = $urandom_range(1, 30);
    mode = $urandom_range(0, 9);
    if (mode == 0) len = $urandom_range(60, 80);
    if (len > budget) len = budget;
    if (len < 1) len = 1;
    for (int k = 0; k < 4; k++) begin
      cxs[k] = $urandom_range(0, 4000) - 2000;
      cys[k] = $urandom_range(0, 4000) - 2000;
    end
    score = 16'($urandom_range(30000, 65535));
    for (int n = 0; n < len; n++) begin
      if (mode == 1) begin
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), n == len - 1);
      end else if (mode == 0) begin
        // disjoint grid so the store fills
        x1 = 16'(n * 80 - 3000);
        y1 = 16'((n % 7) * 90);
        send_box(x1, y1, 16'(x1 + 60), 16'(y1 + 60), score, n == len - 1);
      end else begin
        step = $urandom_range(0, 2);
        cx = cxs[step] + $urandom_range(0, 200) - 100;
        cy = cys[step] + $urandom_range(0, 200) - 100;
        w = $urandom_range(0, 800);
        h = $urandom_range(0, 800);
        if ($urandom_range(0, 19) == 0)
          send_box(16'(cx + w), 16'(cy), 16'(cx), 16'(cy + h), score, n == len - 1);
        else
          send_box(16'(cx), 16'(cy), 16'(cx + w), 16'(cy + h), score, n == len - 1);
      end
      if ($urandom_range(0, 29) == 0) score = 16'($urandom);
      else score = (score > 2000) ? 16'(score - $urandom_range(0, 2000)) : 16'd0;
    end
  endtask

  initial begin
    logic [15:0] settings[10][4];
    int budget;
    settings = '{'{16'd32768, 16'd102, 16'd4096, 16'd64},
                 '{16'd0, 16'd0, 16'd65535, 16'd64},
                 '{16'd65535, 16'd256, 16'd1, 16'd1},
                 '{16'd1000, 16'd511, 16'd0, 16'd5},
                 '{16'd20000, 16'd128, 16'd3, 16'd0},
                 '{16'd0, 16'd50, 16'd10, 16'd127},
                 '{16'd100, 16'd200, 16'd65535, 16'd2},
                 '{16'd40000, 16'd1, 16'd20, 16'd64},
                 '{16'd0, 16'd102, 16'd4096, 16'd64},
                 '{16'd0, 16'd300, 16'd65535, 16'd64}};
    boxes_sent = 0;
    rst = 1;
    cfg_write = 0;
    cfg_index = nms_pkg::REG_SCORE_THR;
    cfg_data = '0;
    in_valid = 0;
    box_x1 = '0; box_y1 = '0; box_x2 = '0; box_y2 = '0;
    box_score = '0;
    frame_last = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: reset thresholds
    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'hFFFF, 0);
    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'hF000, 0);
    send_box(16'sd10, 16'sd10, 16'sd110, 16'sd110, 16'hE000, 0);
    send_box(16'sd500, 16'sd500, 16'sd600, 16'sd600, 16'hD000, 0);
    send_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'hC000, 0);
    send_box(16'sd900, 16'sd900, 16'sd800, 16'sd800, 16'hB000, 0);
    send_box(16'sd2000, 16'sd2000, 16'sd2000, 16'sd2500, 16'h9000, 0);
    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h7FFF, 0);
    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h0000, 1);
    set_thresholds(16'd0, 16'd0, 16'd3, 16'd64);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'd9, 0);
    send_box(16'sd20, 16'sd0, 16'sd30, 16'sd10, 16'd8, 0);
    send_box(16'sd21, 16'sd0, 16'sd31, 16'sd10, 16'd7, 0);
    send_box(16'sd100, 16'sd0, 16'sd110, 16'sd10, 16'd6, 1);
    set_thresholds(16'd0, 16'd256, 16'd0, 16'd2);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'd9, 1);
    set_thresholds(16'd0, 16'd256, 16'd100, 16'd2);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'd9, 0);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'd8, 0);
    send_box(16'sd50, 16'sd0, 16'sd60, 16'sd10, 16'd7, 0);
    send_box(16'sd90, 16'sd0, 16'sd99, 16'sd10, 16'd6, 1);
    set_thresholds(16'd0, 16'd511, 16'd100, 16'd0);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'd9, 1);

    for (int p = 0; p < 10; p++) begin
      set_thresholds(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
      budget = 93;
      while (budget > 0) begin
        int before_n;
        before_n = boxes_sent;
        send_frame(budget);
        budget -= boxes_sent - before_n;
      end
    end

    drain_block();
    $display("sent %0d box requests over 10 threshold settings plus directed cases;",
             boxes_sent);
    $display("kept %0d, suppressed %0d, rest dropped by score or limits",
             kept_total, suppressed_total);
    if (fail_count == 0) begin
      $display("greedy_iou_box_suppression_tb: PASS");
    end else begin
      $display("greedy_iou_box_suppression_tb: FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
design/nms_pkg.sv
design/nms_cell.sv
design/greedy_iou_box_suppression.sv
bench/nms_outcome_checker.sv
bench/greedy_iou_box_suppression_tb.sv
